// ----- hdl/precedence_calculator_engine_macros.svh -----
// ---------------------------------------------------------------------------
// Precedence calculator engine assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef PRECEDENCE_CALCULATOR_ENGINE_MACROS_SVH
`define PRECEDENCE_CALCULATOR_ENGINE_MACROS_SVH

// Same-cycle implication.
`define PCE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pce_pkg.sv -----
// ---------------------------------------------------------------------------
// Precedence calculator engine package
// Widths, key codes, controller states, command and status groups and the
// saturation helpers shared by the engine modules.
// ---------------------------------------------------------------------------
package pce_pkg;

  localparam int VALUE_WIDTH   = 48;
  localparam int FRACTION_BITS = 16;
  localparam int OP_W          = 3;
  localparam int DIV_W         = VALUE_WIDTH + FRACTION_BITS;
  localparam int PROD_W        = 2 * VALUE_WIDTH;
  localparam int SAT_W         = PROD_W + FRACTION_BITS;
  localparam int CNT_W         = $clog2(DIV_W + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [VALUE_WIDTH-1:0]        mag_t;
  typedef logic [VALUE_WIDTH:0]          ext_t;
  typedef logic [DIV_W-1:0]              div_t;
  typedef logic [PROD_W-1:0]             prod_t;
  typedef logic [SAT_W-1:0]              sat_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic [OP_W-1:0]               op_t;

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_NONE   = OP_W'(0),
    OP_ADD    = OP_W'(1),
    OP_SUB    = OP_W'(2),
    OP_MUL    = OP_W'(3),
    OP_DIV    = OP_W'(4),
    OP_EQUALS = OP_W'(5)
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK1,
    ST_RUN1,
    ST_CHECK2,
    ST_RUN2,
    ST_DONE,
    ST_PASS,
    ST_FAIL
  } state_e;

  typedef struct packed {
    logic load;
    logic eval_start;
    logic eval_take;
    logic promote;
    logic defer;
    logic write_ok;
    logic write_pass;
    logic write_fail;
  } cmd_t;

  typedef struct packed {
    logic key_valid;
    logic dop_nz;
    logic np_nz;
    logic outranks;
    logic div0;
    logic alu_done;
    logic out_free;
  } status_t;

  function automatic logic is_high(op_t op);
    return (op == OP_MUL) || (op == OP_DIV);
  endfunction

  function automatic mag_t magnitude(value_t v);
    return v[VALUE_WIDTH-1] ? mag_t'(~v + value_t'(1)) : mag_t'(v);
  endfunction

  // Applies a sign to an unsigned magnitude and clamps to the value range.
  function automatic value_t sat_result(logic neg, sat_t mag);
    logic hi_nz;
    logic top;
    logic low_nz;
    mag_t low;
    hi_nz  = |mag[SAT_W-1:VALUE_WIDTH];
    top    = mag[VALUE_WIDTH-1];
    low_nz = |mag[VALUE_WIDTH-2:0];
    low    = mag[VALUE_WIDTH-1:0];
    if (neg) begin
      if (hi_nz || (top && low_nz)) return VALUE_MIN;
      return value_t'(~low + mag_t'(1));
    end
    if (hi_nz || top) return VALUE_MAX;
    return value_t'(low);
  endfunction

endpackage

// ----- hdl/pce_alu.sv -----
// ---------------------------------------------------------------------------
// Precedence calculator engine arithmetic unit
// Saturating add and subtract, shift-add multiply and restoring
// divide one bit per cycle on magnitudes, with the sign applied at the end.
// ---------------------------------------------------------------------------
module pce_alu (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  pce_pkg::op_t    op_i,
  input  pce_pkg::value_t a_i,
  input  pce_pkg::value_t b_i,
  output logic            done_o,
  output pce_pkg::value_t result_o
);

  logic            run_q, run_d;
  logic            post_q, post_d;
  logic            done_q, done_d;
  logic            is_div_q, is_div_d;
  logic            neg_q, neg_d;
  pce_pkg::cnt_t   cnt_q, cnt_d;
  pce_pkg::ext_t   hi_q, hi_d;
  pce_pkg::mag_t   mcand_q, mcand_d;
  pce_pkg::div_t   lo_q, lo_d;
  pce_pkg::value_t res_q, res_d;

  pce_pkg::ext_t  sum_add;
  pce_pkg::ext_t  sum_sub;
  pce_pkg::ext_t  rsh;
  pce_pkg::ext_t  rdiff;
  logic           fits;
  pce_pkg::mag_t  addend;
  pce_pkg::ext_t  msum;
  pce_pkg::prod_t prod;

  function automatic pce_pkg::value_t clamp(pce_pkg::ext_t s);
    if (s[pce_pkg::VALUE_WIDTH] != s[pce_pkg::VALUE_WIDTH-1]) begin
      return s[pce_pkg::VALUE_WIDTH] ? pce_pkg::VALUE_MIN : pce_pkg::VALUE_MAX;
    end
    return pce_pkg::value_t'(s[pce_pkg::VALUE_WIDTH-1:0]);
  endfunction

  assign sum_add = {a_i[pce_pkg::VALUE_WIDTH-1], a_i} + {b_i[pce_pkg::VALUE_WIDTH-1], b_i};
  assign sum_sub = {a_i[pce_pkg::VALUE_WIDTH-1], a_i} - {b_i[pce_pkg::VALUE_WIDTH-1], b_i};

  assign rsh    = {hi_q[pce_pkg::VALUE_WIDTH-1:0], lo_q[pce_pkg::DIV_W-1]};
  assign fits   = rsh >= {1'b0, mcand_q};
  assign rdiff  = rsh - {1'b0, mcand_q};
  assign addend = lo_q[0] ? mcand_q : pce_pkg::mag_t'(0);
  assign msum   = hi_q + {1'b0, addend};
  assign prod   = {hi_q[pce_pkg::VALUE_WIDTH-1:0], lo_q[pce_pkg::VALUE_WIDTH-1:0]};

  always_comb begin
    run_d    = run_q;
    post_d   = post_q;
    done_d   = 1'b0;
    is_div_d = is_div_q;
    neg_d    = neg_q;
    cnt_d    = cnt_q;
    hi_d     = hi_q;
    mcand_d  = mcand_q;
    lo_d     = lo_q;
    res_d    = res_q;
    if (start_i) begin
      neg_d   = a_i[pce_pkg::VALUE_WIDTH-1] ^ b_i[pce_pkg::VALUE_WIDTH-1];
      mcand_d = pce_pkg::magnitude(b_i);
      hi_d    = '0;
      unique case (op_i)
        pce_pkg::OP_ADD: begin
          res_d  = clamp(sum_add);
          done_d = 1'b1;
        end
        pce_pkg::OP_SUB: begin
          res_d  = clamp(sum_sub);
          done_d = 1'b1;
        end
        pce_pkg::OP_MUL: begin
          lo_d     = pce_pkg::div_t'(pce_pkg::magnitude(a_i));
          cnt_d    = pce_pkg::cnt_t'(pce_pkg::VALUE_WIDTH);
          is_div_d = 1'b0;
          run_d    = 1'b1;
        end
        pce_pkg::OP_DIV: begin
          lo_d     = pce_pkg::div_t'(pce_pkg::magnitude(a_i)) << pce_pkg::FRACTION_BITS;
          cnt_d    = pce_pkg::cnt_t'(pce_pkg::DIV_W);
          is_div_d = 1'b1;
          run_d    = 1'b1;
        end
        default: begin
          res_d  = b_i;
          done_d = 1'b1;
        end
      endcase
    end else if (run_q) begin
      cnt_d = cnt_q - pce_pkg::cnt_t'(1);
      if (cnt_q == pce_pkg::cnt_t'(1)) begin
        run_d  = 1'b0;
        post_d = 1'b1;
      end
      if (is_div_q) begin
        hi_d = fits ? rdiff : rsh;
        lo_d = {lo_q[pce_pkg::DIV_W-2:0], fits};
      end else begin
        hi_d = {1'b0, msum[pce_pkg::VALUE_WIDTH:1]};
        lo_d = pce_pkg::div_t'({msum[0], lo_q[pce_pkg::VALUE_WIDTH-1:1]});
      end
    end else if (post_q) begin
      post_d = 1'b0;
      done_d = 1'b1;
      res_d  = pce_pkg::sat_result(neg_q, is_div_q ? pce_pkg::sat_t'(lo_q)
                                   : pce_pkg::sat_t'(prod >> pce_pkg::FRACTION_BITS));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      post_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      post_q <= post_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_div_q <= is_div_d;
    neg_q    <= neg_d;
    cnt_q    <= cnt_d;
    hi_q     <= hi_d;
    mcand_q  <= mcand_d;
    lo_q     <= lo_d;
    res_q    <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ----- hdl/pce_dp.sv -----
// ---------------------------------------------------------------------------
// Precedence calculator engine datapath
// Pending and deferred operator state, the working copy of one key step,
// the arithmetic unit and the output register.
// ---------------------------------------------------------------------------
`include "precedence_calculator_engine_macros.svh"

module pce_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pce_pkg::cmd_t     cmd_i,
  output pce_pkg::status_t  status_o,
  input  pce_pkg::op_t      in_op_i,
  input  pce_pkg::value_t   in_value_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output pce_pkg::value_t   m_value_o,
  output logic [1:0]        m_flags_o
);

  pce_pkg::op_t    pend_op_q, pend_op_d;
  pce_pkg::value_t pend_val_q, pend_val_d;
  logic [1:0]      def_op_q, def_op_d;
  pce_pkg::value_t def_val_q, def_val_d;

  pce_pkg::op_t    key_q, key_d;
  pce_pkg::value_t entered_q, entered_d;
  pce_pkg::value_t disp_q, disp_d;
  pce_pkg::op_t    np_q, np_d;
  pce_pkg::value_t nv_q, nv_d;
  logic [1:0]      dop_q, dop_d;
  pce_pkg::value_t dv_q, dv_d;
  logic            changed_q, changed_d;

  logic            m_valid_q, m_valid_d;
  pce_pkg::value_t m_value_q, m_value_d;
  logic [1:0]      m_flags_q, m_flags_d;

  logic            alu_done;
  pce_pkg::value_t alu_result;

  pce_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.eval_start),
    .op_i    (np_q),
    .a_i     (nv_q),
    .b_i     (disp_q),
    .done_o  (alu_done),
    .result_o(alu_result)
  );

  always_comb begin
    status_o.key_valid = (key_q != pce_pkg::OP_NONE) && (key_q <= pce_pkg::OP_EQUALS);
    status_o.dop_nz    = dop_q != 2'b00;
    status_o.np_nz     = np_q != pce_pkg::OP_NONE;
    status_o.outranks  = pce_pkg::is_high(key_q) && !pce_pkg::is_high(np_q);
    status_o.div0      = (np_q == pce_pkg::OP_DIV) && (disp_q == '0);
    status_o.alu_done  = alu_done;
    status_o.out_free  = !m_valid_q || m_ready_i;
  end

  always_comb begin
    pend_op_d  = pend_op_q;
    pend_val_d = pend_val_q;
    def_op_d   = def_op_q;
    def_val_d  = def_val_q;
    key_d      = key_q;
    entered_d  = entered_q;
    disp_d     = disp_q;
    np_d       = np_q;
    nv_d       = nv_q;
    dop_d      = dop_q;
    dv_d       = dv_q;
    changed_d  = changed_q;
    m_valid_d  = m_valid_q;
    m_value_d  = m_value_q;
    m_flags_d  = m_flags_q;

    if (cmd_i.load) begin
      key_d     = in_op_i;
      entered_d = in_value_i;
      disp_d    = in_value_i;
      np_d      = pend_op_q;
      nv_d      = pend_val_q;
      dop_d     = def_op_q;
      dv_d      = def_val_q;
      changed_d = 1'b0;
    end
    if (cmd_i.eval_take) begin
      disp_d    = alu_result;
      changed_d = 1'b1;
    end
    if (cmd_i.promote) begin
      np_d  = {1'b0, dop_q};
      nv_d  = dv_q;
      dop_d = 2'b00;
    end
    if (cmd_i.defer) begin
      dop_d = np_q[1:0];
      dv_d  = nv_q;
    end

    if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
    if (cmd_i.write_ok) begin
      pend_op_d  = (key_q == pce_pkg::OP_EQUALS) ? pce_pkg::op_t'(pce_pkg::OP_NONE) : key_q;
      pend_val_d = disp_q;
      def_op_d   = dop_q;
      def_val_d  = dv_q;
      m_valid_d  = 1'b1;
      m_value_d  = disp_q;
      m_flags_d  = {1'b0, changed_q};
    end else if (cmd_i.write_pass || cmd_i.write_fail) begin
      m_valid_d = 1'b1;
      m_value_d = entered_q;
      m_flags_d = {cmd_i.write_fail, 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_op_q  <= pce_pkg::OP_NONE;
      pend_val_q <= '0;
      def_op_q   <= 2'b00;
      def_val_q  <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      pend_op_q  <= pend_op_d;
      pend_val_q <= pend_val_d;
      def_op_q   <= def_op_d;
      def_val_q  <= def_val_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    entered_q <= entered_d;
    disp_q    <= disp_d;
    np_q      <= np_d;
    nv_q      <= nv_d;
    dop_q     <= dop_d;
    dv_q      <= dv_d;
    changed_q <= changed_d;
    m_value_q <= m_value_d;
    m_flags_q <= m_flags_d;
  end

  assign m_valid_o = m_valid_q;
  assign m_value_o = m_value_q;
  assign m_flags_o = m_flags_q;

  // A refused division must leave the calculator state untouched.
  `PCE_ASSERT_NEXT(a_fail_keeps_state, cmd_i.write_fail, $stable(pend_op_q) && $stable(pend_val_q) && $stable(def_op_q) && $stable(def_val_q), "refused division changed state")

endmodule

// ----- hdl/pce_ctrl.sv -----
// ---------------------------------------------------------------------------
// Precedence calculator engine controller
// Sequences one key: deferred evaluation, precedence decision, pending
// evaluation and the final result write.
// ---------------------------------------------------------------------------
`include "precedence_calculator_engine_macros.svh"

module pce_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  pce_pkg::status_t status_i,
  output pce_pkg::cmd_t    cmd_o
);

  pce_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pce_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      pce_pkg::ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = pce_pkg::ST_CHECK1;
        end
      end
      pce_pkg::ST_CHECK1: begin
        if (!status_i.key_valid) begin
          state_d = pce_pkg::ST_PASS;
        end else if (status_i.dop_nz) begin
          if (status_i.div0) begin
            state_d = pce_pkg::ST_FAIL;
          end else begin
            cmd_o.eval_start = 1'b1;
            state_d          = pce_pkg::ST_RUN1;
          end
        end else begin
          state_d = pce_pkg::ST_CHECK2;
        end
      end
      pce_pkg::ST_RUN1: begin
        if (status_i.alu_done) begin
          cmd_o.eval_take = 1'b1;
          cmd_o.promote   = 1'b1;
          state_d         = pce_pkg::ST_CHECK2;
        end
      end
      pce_pkg::ST_CHECK2: begin
        if (!status_i.np_nz) begin
          state_d = pce_pkg::ST_DONE;
        end else if (status_i.outranks) begin
          cmd_o.defer = 1'b1;
          state_d     = pce_pkg::ST_DONE;
        end else if (status_i.div0) begin
          state_d = pce_pkg::ST_FAIL;
        end else begin
          cmd_o.eval_start = 1'b1;
          state_d          = pce_pkg::ST_RUN2;
        end
      end
      pce_pkg::ST_RUN2: begin
        if (status_i.alu_done) begin
          cmd_o.eval_take = 1'b1;
          state_d         = pce_pkg::ST_DONE;
        end
      end
      pce_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.write_ok = 1'b1;
          state_d        = pce_pkg::ST_IDLE;
        end
      end
      pce_pkg::ST_PASS: begin
        if (status_i.out_free) begin
          cmd_o.write_pass = 1'b1;
          state_d          = pce_pkg::ST_IDLE;
        end
      end
      pce_pkg::ST_FAIL: begin
        if (status_i.out_free) begin
          cmd_o.write_fail = 1'b1;
          state_d          = pce_pkg::ST_IDLE;
        end
      end
    endcase
  end

  `PCE_ASSERT_NOW(a_write_has_room, cmd_o.write_ok || cmd_o.write_pass || cmd_o.write_fail, status_i.out_free, "result written over an untaken item")
  `PCE_ASSERT_NOW(a_done_while_waiting, status_i.alu_done, state_q == pce_pkg::ST_RUN1 || state_q == pce_pkg::ST_RUN2, "arithmetic finished with no evaluation waiting")
  `PCE_ASSERT_NOW(a_no_zero_divide, cmd_o.eval_start, !status_i.div0, "division by zero started")

endmodule

// ----- hdl/precedence_calculator_engine.sv -----
// ---------------------------------------------------------------------------
// Precedence calculator engine
// Key-sequence engine of a four-function calculator with two precedence
// levels on signed saturating fixed point values.
// ---------------------------------------------------------------------------
// One key item is handled at a time. An ignored key passes through CHECK1
// and PASS to the result register, and a key that evaluates nothing through
// CHECK1, CHECK2 and DONE. Each evaluation waits in RUN1 or RUN2 for the
// shared arithmetic unit, which forms one product or quotient bit per cycle
// for a multiply or a divide; the slowest key is a deferred step behind a
// divide. The next key is accepted in the cycle after the result is written,
// while that result may still wait in the output register; a result that is
// not taken holds the following key at its final write.
module precedence_calculator_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // entered_value[47:0]
  input  logic [2:0]  s_axis_tuser_i,   // op[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // display_value[47:0]
  output logic [1:0]  m_axis_tuser_o    // display_changed[0], div_error[1]
);

  pce_pkg::cmd_t    cmd;
  pce_pkg::status_t status;
  pce_pkg::value_t  m_value;

  pce_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid_i),
    .s_ready_o(s_axis_tready_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  pce_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .in_op_i   (s_axis_tuser_i),
    .in_value_i(pce_pkg::value_t'(s_axis_tdata_i)),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_value_o (m_value),
    .m_flags_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = m_value;

endmodule

// ----- tb/sv/tb_precedence_calculator_engine.sv -----
// ---------------------------------------------------------------------------
// Precedence calculator engine testbench
// Streams key items into the engine and checks every result item against a
// behavioral model of the two-level precedence calculator. The model covers
// saturating fixed point arithmetic, deferred add and subtract, and refused
// division by zero. Directed keys come first, then random key sequences
// under several idle patterns and one long output stall.
// ---------------------------------------------------------------------------
module tb_precedence_calculator_engine;
  import pce_pkg::*;

  localparam op_t KEY_RSVD6    = 3'd6;
  localparam op_t KEY_RSVD7    = 3'd7;
  localparam int  HOLD_CYCLES  = 300;
  localparam int  STUCK_LIMIT  = 4000;
  localparam int  DRAIN_CYCLES = 100;

  typedef logic [2*VALUE_WIDTH-1:0]         wide_t;
  typedef logic [VALUE_WIDTH-1:0]           absval_t;
  typedef logic [VALUE_WIDTH+FRACTION_BITS-1:0] quot_t;

  typedef struct packed {
    value_t display;
    logic   changed;
    logic   div_error;
  } display_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;   // entered_value[47:0]
  logic [2:0]  s_axis_tuser_i = '0;   // op[2:0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;        // display_value[47:0]
  logic [1:0]  m_axis_tuser_o;        // display_changed[0], div_error[1]

  op_t          pend_op   = OP_NONE;
  value_t       pend_val  = '0;
  logic [1:0]   defer_op  = 2'd0;
  value_t       defer_val = '0;
  display_t     display_q[$];
  int           mismatch_count = 0;
  int           sender_idle_pct = 0;
  int           stall_pct = 0;
  int           hold_token = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  int           stuck_cycles = 0;

  precedence_calculator_engine uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic absval_t abs_value(value_t v);
    return v[VALUE_WIDTH-1] ? ~v + 1'b1 : v;
  endfunction

  function automatic value_t saturate_mag(logic neg, wide_t mag);
    wide_t lim;
    lim = wide_t'(absval_t'(VALUE_MAX));
    if (neg) begin
      if (mag > lim + 1'b1) return VALUE_MIN;
      return value_t'(~mag + 1'b1);
    end
    if (mag > lim) return VALUE_MAX;
    return value_t'(mag);
  endfunction

  // Returns 0 when a division by zero is refused.
  function automatic logic apply_key_op(op_t k, value_t a, value_t b, output value_t r);
    logic [VALUE_WIDTH:0] sum;
    wide_t                prod;
    quot_t                num;
    quot_t                den;
    logic                 neg;
    neg = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
    r = b;
    case (k)
      OP_ADD, OP_SUB: begin
        if (k == OP_ADD) sum = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
        else             sum = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
        if (sum[VALUE_WIDTH] != sum[VALUE_WIDTH-1]) r = sum[VALUE_WIDTH] ? VALUE_MIN : VALUE_MAX;
        else r = value_t'(sum);
      end
      OP_MUL: begin
        prod = wide_t'(abs_value(a)) * wide_t'(abs_value(b));
        r = saturate_mag(neg, prod >> FRACTION_BITS);
      end
      OP_DIV: begin
        if (b == '0) return 1'b0;
        num = {abs_value(a), {FRACTION_BITS{1'b0}}};
        den = quot_t'(abs_value(b));
        r = saturate_mag(neg, wide_t'(num / den));
      end
      default: r = b;
    endcase
    return 1'b1;
  endfunction

  function automatic logic binds_tight(op_t k);
    return (k == OP_MUL) || (k == OP_DIV);
  endfunction

  function automatic display_t step_calculator(op_t key, value_t entered);
    display_t   res;
    op_t        np;
    logic [1:0] dop;
    value_t     nv;
    value_t     dv;
    value_t     disp;
    value_t     r;
    np = pend_op;
    dop = defer_op;
    nv = pend_val;
    dv = defer_val;
    disp = entered;
    res = '{display: entered, changed: 1'b0, div_error: 1'b0};
    if (key == OP_NONE || key > OP_EQUALS) return res;
    if (dop != 2'd0) begin
      if (!apply_key_op(np, nv, disp, r)) begin
        res.div_error = 1'b1;
        return res;
      end
      disp = r;
      res.changed = 1'b1;
      np = op_t'(dop);
      nv = dv;
      dop = 2'd0;
    end
    if (np != OP_NONE) begin
      if (binds_tight(key) && !binds_tight(np)) begin
        dop = np[1:0];
        dv = nv;
      end else begin
        if (!apply_key_op(np, nv, disp, r)) begin
          res.div_error = 1'b1;
          res.changed = 1'b0;
          return res;
        end
        disp = r;
        res.changed = 1'b1;
      end
    end
    pend_op = (key == OP_EQUALS) ? OP_NONE : key;
    pend_val = disp;
    defer_op = dop;
    defer_val = dv;
    res.display = disp;
    return res;
  endfunction

  function automatic value_t to_fixed(int n);
    return value_t'(n) <<< FRACTION_BITS;
  endfunction

  function automatic value_t random_value();
    value_t v;
    v = value_t'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0: v = '0;
      1: begin
        case ($urandom_range(0, 3))
          0:       v = VALUE_MAX;
          1:       v = VALUE_MIN;
          2:       v = value_t'(1);
          default: v = value_t'(-1);
        endcase
      end
      2, 3: v = v;
      default: v = v >>> $urandom_range(16, 44);
    endcase
    return v;
  endfunction

  task automatic log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Called in the time step of a rising edge; returns in the step of the edge
  // at which the item was accepted.
  task automatic send_key(op_t key, value_t value);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tuser_i  <= key;
    @(negedge clk_i);
    while (!s_axis_tready_o) @(negedge clk_i);
    @(posedge clk_i);
    display_q.push_back(step_calculator(key, value));
  endtask

  task automatic run_random_keys(int key_count);
    int  sent;
    int  len;
    op_t key;
    sent = 0;
    while (sent < key_count) begin
      if ($urandom_range(0, 9) == 0) begin
        key = op_t'($urandom_range(0, 7));
        send_key(key, random_value());
        if (key != OP_NONE && key <= OP_EQUALS) sent++;
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          send_key(op_t'($urandom_range(int'(OP_ADD), int'(OP_DIV))), random_value());
          sent++;
        end
        send_key(OP_EQUALS, random_value());
        sent++;
      end
    end
  endtask

  task automatic test_directed_keys();
    sender_idle_pct = 0;
    stall_pct = 0;
    send_key(OP_NONE, VALUE_MAX);
    send_key(KEY_RSVD6, VALUE_MIN);
    send_key(KEY_RSVD7, value_t'(-1));
    send_key(OP_ADD, VALUE_MAX);
    send_key(OP_EQUALS, to_fixed(1));
    send_key(OP_SUB, VALUE_MIN);
    send_key(OP_EQUALS, to_fixed(1));
    send_key(OP_ADD, to_fixed(1));
    send_key(OP_MUL, to_fixed(2));
    send_key(OP_MUL, to_fixed(3));
    send_key(OP_EQUALS, to_fixed(4));
    send_key(OP_DIV, to_fixed(5));
    send_key(OP_EQUALS, '0);
    send_key(OP_EQUALS, to_fixed(2));
    send_key(OP_SUB, to_fixed(1));
    send_key(OP_DIV, to_fixed(6));
    send_key(OP_ADD, '0);
    send_key(OP_ADD, to_fixed(3));
    send_key(OP_EQUALS, to_fixed(1));
    send_key(OP_MUL, VALUE_MAX);
    send_key(OP_EQUALS, VALUE_MAX);
    send_key(OP_DIV, VALUE_MIN);
    send_key(OP_EQUALS, value_t'(-1));
  endtask

  task automatic test_random_streaming();
    sender_idle_pct = 0;
    stall_pct = 0;
    run_random_keys(400);
  endtask

  task automatic test_random_sender_gaps();
    sender_idle_pct = 85;
    stall_pct = 0;
    run_random_keys(400);
  endtask

  task automatic test_random_receiver_stalls();
    sender_idle_pct = 0;
    stall_pct = 85;
    run_random_keys(400);
  endtask

  task automatic test_random_both_idle();
    sender_idle_pct = 7;
    stall_pct = 7;
    run_random_keys(400);
  endtask

  // The receiver holds off long enough that the engine fills and blocks its
  // input while the sender keeps offering items.
  task automatic test_output_backpressure();
    sender_idle_pct = 0;
    stall_pct = 0;
    s_axis_tvalid_i <= 1'b0;
    while (display_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    hold_token++;
    @(posedge clk_i);
    run_random_keys(40);
  endtask

  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(negedge clk_i) begin
    display_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (display_q.size() == 0) begin
        log_mismatch($sformatf("unexpected result display %h changed %b div_error %b",
                               m_axis_tdata_o, m_axis_tuser_o[0], m_axis_tuser_o[1]));
      end else begin
        want = display_q.pop_front();
        if (m_axis_tdata_o !== want.display || m_axis_tuser_o[0] !== want.changed ||
            m_axis_tuser_o[1] !== want.div_error) begin
          log_mismatch($sformatf("display %h changed %b div_error %b, expected %h %b %b",
                                 m_axis_tdata_o, m_axis_tuser_o[0], m_axis_tuser_o[1],
                                 want.display, want.changed, want.div_error));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("tb_precedence_calculator_engine: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_keys();
    test_random_streaming();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_idle();
    test_output_backpressure();
    s_axis_tvalid_i <= 1'b0;
    while (display_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && display_q.size() == 0) begin
      $display("tb_precedence_calculator_engine: PASS");
    end else begin
      $display("tb_precedence_calculator_engine: FAIL");
    end
    $finish;
  end

endmodule
